/* sv/cgd_pkg.sv */
// Shared types, constants and constant tables of the compressor gain detector.
// Holds the log2 table and the opto coefficient tables built for the sample rate.
// Used by every module of the block; depends on nothing else.
package cgd_pkg;

    localparam int SAMPLE_RATE     = 48000;
    localparam int LOG_TABLE_DEPTH = 256;
    localparam int LOG_BITS        = $clog2(LOG_TABLE_DEPTH);
    localparam int FRAC_BITS       = 23 - LOG_BITS;

    localparam int ATK_LAST = 24;
    localparam int REL_LAST = 20;

    typedef struct packed {
        logic [15:0] slope_q15;
        logic [1:0]  drive_mode;
        logic        opto_enable;
        logic [15:0] attack_coeff;
        logic [15:0] release_coeff;
        logic [15:0] level_coeff;
        logic [15:0] memory_coeff;
    } cfg_t;

    typedef enum logic [2:0] {
        REG_SLOPE   = 3'd0,
        REG_DRIVE   = 3'd1,
        REG_OPTO    = 3'd2,
        REG_ATTACK  = 3'd3,
        REG_RELEASE = 3'd4,
        REG_LEVEL   = 3'd5,
        REG_MEMORY  = 3'd6
    } reg_idx_t;

    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LOAD   = 4'd1,
        OP_FILT   = 4'd2,
        OP_NORM0  = 4'd3,
        OP_NORM   = 4'd4,
        OP_INTERP = 4'd5,
        OP_LOGMUL = 4'd6,
        OP_KNEE1  = 4'd7,
        OP_KNEE2  = 4'd8,
        OP_KNEE3  = 4'd9,
        OP_BITE   = 4'd10,
        OP_ATK    = 4'd11,
        OP_MEM    = 4'd12,
        OP_REL    = 4'd13,
        OP_GAIN   = 4'd14,
        OP_OUT    = 4'd15
    } op_t;

    typedef enum logic [1:0] {
        RG_BELOW = 2'd0,
        RG_KNEE  = 2'd1,
        RG_ABOVE = 2'd2
    } region_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] step;
    } cmd_t;

    typedef struct packed {
        region_t region;
        logic    opto;
    } status_t;

    typedef logic [15:0] log_tab_t [LOG_TABLE_DEPTH];
    typedef logic [15:0] atk_rom_t [ATK_LAST + 1];
    typedef logic [15:0] rel_rom_t [REL_LAST + 1];

    // Unsigned quotient by shift and subtract, evaluated while the tables are built.
    function automatic logic [63:0] const_div(logic [63:0] num, logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // log2 of 1 + i/depth in Q.16, found by repeated squaring.
    function automatic log_tab_t build_log_tab();
        log_tab_t    tab;
        logic [63:0] m;
        logic [15:0] r;
        for (int i = 0; i < LOG_TABLE_DEPTH; i++)
        begin
            m = (64'd1 << 30) + ((64'(i) << 30) >> LOG_BITS);
            r = '0;
            for (int b = 15; b >= 0; b--)
            begin
                m = (m * m) >> 30;
                if (m >= (64'd1 << 31))
                begin
                    r[b] = 1'b1;
                    m = m >> 1;
                end
            end
            tab[i] = r;
        end
        return tab;
    endfunction

    // exp(-x) in Q0.16 for x in Q.32, by a Taylor series.
    function automatic logic [15:0] exp_from_x(logic [63:0] x);
        logic [63:0]        xx;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        r;
        xx = (x > (64'd1 << 31)) ? (64'd1 << 31) : x;
        term = 64'd1 << 32;
        sum = 64'sd1 <<< 32;
        for (int k = 1; k <= 14; k++)
        begin
            term = const_div((term * xx) >> 32, 64'(k));
            if ((k & 1) == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        r = ($unsigned(sum) + 64'd32768) >> 16;
        return (r > 64'd65535) ? 16'hffff : r[15:0];
    endfunction

    function automatic atk_rom_t build_atk_rom();
        atk_rom_t    rom;
        logic [63:0] x;
        for (int i = 0; i <= ATK_LAST; i++)
        begin
            x = const_div(64'd6000 << 32, 64'(48 + 13 * i) * 64'(SAMPLE_RATE));
            rom[i] = exp_from_x(x);
        end
        return rom;
    endfunction

    function automatic rel_rom_t build_rel_rom();
        rel_rom_t    rom;
        logic [63:0] x;
        for (int i = 0; i <= REL_LAST; i++)
        begin
            x = const_div(64'd1000 << 32, 64'(300 + 135 * i) * 64'(SAMPLE_RATE));
            rom[i] = exp_from_x(x);
        end
        return rom;
    endfunction

    localparam log_tab_t LOG_TAB = build_log_tab();
    localparam atk_rom_t ATK_ROM = build_atk_rom();
    localparam rel_rom_t REL_ROM = build_rel_rom();
    localparam logic [15:0] FAST_ATK =
        exp_from_x(const_div(64'd10000 << 32, 64'd3 * 64'(SAMPLE_RATE)));

    // Gain computer constants per drive mode.
    localparam logic [11:0] KNEE_NORMAL = 12'd1536;
    localparam logic [11:0] KNEE_NUKE   = 12'd256;
    localparam logic [11:0] KNEE_BIG    = 12'd77;
    localparam logic [24:0] RECIP_NORMAL = 25'd5592406;
    localparam logic [24:0] RECIP_NUKE   = 25'd16777216;
    localparam logic [24:0] RECIP_BIG    = 25'd217886;
    localparam logic [16:0] BITE_NORMAL = 17'd65536;
    localparam logic [16:0] BITE_NUKE   = 17'd75366;
    localparam logic [16:0] BITE_BIG    = 17'd88474;
    localparam logic [16:0] MAG_BIG     = 17'd32702;

endpackage

/* sv/cgd_regs.sv */
// Configuration registers of the gain detector behind an APB-style port.
// Depends on cgd_pkg for the register indexes and the configuration struct.
module cgd_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output cgd_pkg::cfg_t cfg
);
    import cgd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[4:2])
                REG_SLOPE:   cfg_next.slope_q15     = pwdata[15:0];
                REG_DRIVE:   cfg_next.drive_mode    = pwdata[1:0];
                REG_OPTO:    cfg_next.opto_enable   = pwdata[0];
                REG_ATTACK:  cfg_next.attack_coeff  = pwdata[15:0];
                REG_RELEASE: cfg_next.release_coeff = pwdata[15:0];
                REG_LEVEL:   cfg_next.level_coeff   = pwdata[15:0];
                REG_MEMORY:  cfg_next.memory_coeff  = pwdata[15:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_SLOPE:   prdata = {16'd0, cfg_reg.slope_q15};
            REG_DRIVE:   prdata = {30'd0, cfg_reg.drive_mode};
            REG_OPTO:    prdata = {31'd0, cfg_reg.opto_enable};
            REG_ATTACK:  prdata = {16'd0, cfg_reg.attack_coeff};
            REG_RELEASE: prdata = {16'd0, cfg_reg.release_coeff};
            REG_LEVEL:   prdata = {16'd0, cfg_reg.level_coeff};
            REG_MEMORY:  prdata = {16'd0, cfg_reg.memory_coeff};
            default:     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slope_q15     <= 16'hA000;
            cfg_reg.drive_mode    <= 2'd0;
            cfg_reg.opto_enable   <= 1'b0;
            cfg_reg.attack_coeff  <= 16'd60000;
            cfg_reg.release_coeff <= 16'd65500;
            cfg_reg.level_coeff   <= 16'd60000;
            cfg_reg.memory_coeff  <= 16'd65535;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* sv/cgd_datapath.sv */
// Datapath of the gain detector: state registers, shared multiplier and tables.
// Executes one command from the controller per cycle; depends on cgd_pkg.
module cgd_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  cgd_pkg::cfg_t    cfg,
    input  cgd_pkg::cmd_t    cmd,
    input  logic [15:0]      level,
    output cgd_pkg::status_t sts,
    output logic [13:0]      gain_reduction
);
    import cgd_pkg::*;

    logic [15:0]        x_reg, x_next;
    logic [23:0]        s_reg, s_next;
    logic [23:0]        g_reg, g_next;
    logic [23:0]        r_reg, r_next;
    logic [23:0]        norm_reg, norm_next;
    logic [4:0]         p_reg, p_next;
    logic               zero_reg, zero_next;
    logic signed [22:0] lg_reg, lg_next;
    logic signed [15:0] over_reg, over_next;
    logic [24:0]        tmp_reg, tmp_next;
    logic [15:0]        t_reg, t_next;
    logic [15:0]        ca_reg, ca_next;
    logic [15:0]        cr_reg, cr_next;
    logic [13:0]        out_reg, out_next;

    logic signed [25:0] mul_a, mul_b;
    logic signed [51:0] prod;
    logic [51:0]        prod_u;
    logic signed [51:0] p16;

    logic               big, nuke;
    logic [11:0]        knee_w;
    logic [24:0]        recip;
    logic [5:0]         knee_sh;
    logic [16:0]        bite;
    logic [16:0]        mag;
    logic signed [16:0] slope_neg;
    logic signed [17:0] over2, kn;
    logic signed [17:0] u_full;
    region_t            region;

    logic [23:0]          tq;
    logic [LOG_BITS-1:0]  lidx, lidx_nx;
    logic [FRAC_BITS-1:0] lfrac;
    logic [16:0]          tab_lo, tab_hi, tab_diff;
    logic signed [6:0]    ep;
    logic signed [23:0]   lg_sum;
    logic signed [27:0]   db_w;
    logic signed [15:0]   ldb;

    logic               atk_clamp, rel_clamp;
    logic [4:0]         ai, ri;
    logic [15:0]        atk_lo, atk_hi, rel_lo, rel_hi;
    logic signed [16:0] atk_d, rel_d;
    logic [15:0]        c_sel;
    logic [4:0]         sh;

    function automatic logic signed [25:0] one_minus(logic [15:0] c);
        return $signed(26'(17'h10000 - {1'b0, c}));
    endfunction

    assign big  = cfg.drive_mode[1];
    assign nuke = (cfg.drive_mode == 2'd1);

    always_comb
    begin
        if (big)
        begin
            knee_w = KNEE_BIG;    recip = RECIP_BIG;    knee_sh = 6'd18; bite = BITE_BIG;
        end
        else if (nuke)
        begin
            knee_w = KNEE_NUKE;   recip = RECIP_NUKE;   knee_sh = 6'd26; bite = BITE_NUKE;
        end
        else
        begin
            knee_w = KNEE_NORMAL; recip = RECIP_NORMAL; knee_sh = 6'd27; bite = BITE_NORMAL;
        end
    end

    // Outside the big drive modes, a positive slope gives no reduction at all.
    assign slope_neg = -$signed({cfg.slope_q15[15], cfg.slope_q15});
    assign mag = big ? MAG_BIG : (cfg.slope_q15[15] ? $unsigned(slope_neg) : 17'd0);

    assign over2  = {over_reg[15], over_reg, 1'b0};
    assign kn     = $signed({6'd0, knee_w});
    assign u_full = over2 + kn;

    always_comb
    begin
        if (over2 < -kn)
            region = RG_BELOW;
        else if (over2 <= kn)
            region = RG_KNEE;
        else
            region = RG_ABOVE;
    end

    assign sts.region = region;
    assign sts.opto   = cfg.opto_enable;

    assign tq = {t_reg, 8'd0};

    // Log table lookup on the normalized mantissa.
    assign lidx     = norm_reg[22 -: LOG_BITS];
    assign lidx_nx  = lidx + LOG_BITS'(1);
    assign lfrac    = norm_reg[FRAC_BITS-1:0];
    assign tab_lo   = {1'b0, LOG_TAB[lidx]};
    assign tab_hi   = (lidx == {LOG_BITS{1'b1}}) ? 17'h10000 : {1'b0, LOG_TAB[lidx_nx]};
    assign tab_diff = tab_hi - tab_lo;
    assign ep       = $signed({2'b00, p_reg}) - 7'sd23;

    assign atk_clamp = (tq >= (24'(ATK_LAST) << 16));
    assign rel_clamp = (r_reg >= (24'(REL_LAST) << 16));
    assign ai     = atk_clamp ? 5'(ATK_LAST - 1) : tq[20:16];
    assign ri     = rel_clamp ? 5'(REL_LAST - 1) : r_reg[20:16];
    assign atk_lo = ATK_ROM[ai];
    assign atk_hi = ATK_ROM[ai + 5'd1];
    assign rel_lo = REL_ROM[ri];
    assign rel_hi = REL_ROM[ri + 5'd1];
    assign atk_d  = $signed({1'b0, atk_hi}) - $signed({1'b0, atk_lo});
    assign rel_d  = $signed({1'b0, rel_hi}) - $signed({1'b0, rel_lo});

    assign c_sel = (tq > g_reg) ? ca_reg : cr_reg;
    assign sh    = 5'd16 >> cmd.step;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_FILT:
            begin
                mul_a = $signed({2'b00, x_reg, 8'd0}) - $signed({2'b00, s_reg});
                mul_b = one_minus(cfg.level_coeff);
            end
            OP_INTERP:
            begin
                mul_a = $signed(26'(tab_diff));
                mul_b = $signed(26'(lfrac));
            end
            OP_LOGMUL:
            begin
                mul_a = 26'(lg_reg);
                mul_b = 26'sd394566;
            end
            OP_KNEE1:
            begin
                if (region == RG_KNEE)
                begin
                    mul_a = $signed(26'(u_full[12:0]));
                    mul_b = $signed(26'(u_full[12:0]));
                end
                else
                begin
                    mul_a = 26'(over_reg);
                    mul_b = $signed(26'(mag));
                end
            end
            OP_KNEE2:
            begin
                mul_a = $signed(26'(tmp_reg));
                mul_b = $signed(26'(mag));
            end
            OP_KNEE3:
            begin
                mul_a = $signed(26'(tmp_reg));
                mul_b = $signed(26'(recip));
            end
            OP_BITE:
            begin
                mul_a = $signed(26'(t_reg));
                mul_b = $signed(26'(bite));
            end
            OP_ATK:
            begin
                mul_a = 26'(atk_d);
                mul_b = $signed(26'(tq[15:0]));
            end
            OP_MEM:
            begin
                mul_a = $signed({2'b00, tq}) - $signed({2'b00, r_reg});
                mul_b = one_minus(cfg.memory_coeff);
            end
            OP_REL:
            begin
                mul_a = 26'(rel_d);
                mul_b = $signed(26'(r_reg[15:0]));
            end
            OP_GAIN:
            begin
                mul_a = $signed({2'b00, tq}) - $signed({2'b00, g_reg});
                mul_b = one_minus(c_sel);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod   = mul_a * mul_b;
    assign prod_u = $unsigned(prod);
    assign p16    = prod >>> 16;

    assign lg_sum = ($signed(24'(ep)) <<< 16) + $signed({7'd0, tab_lo})
                  + $signed(24'(prod_u >> FRAC_BITS));
    assign db_w = prod[51:24];
    assign ldb  = (zero_reg || (db_w < -28'sd25600)) ? -16'sd25600 : db_w[15:0];

    always_comb
    begin
        x_next    = x_reg;
        s_next    = s_reg;
        g_next    = g_reg;
        r_next    = r_reg;
        norm_next = norm_reg;
        p_next    = p_reg;
        zero_next = zero_reg;
        lg_next   = lg_reg;
        over_next = over_reg;
        tmp_next  = tmp_reg;
        t_next    = t_reg;
        ca_next   = ca_reg;
        cr_next   = cr_reg;
        out_next  = out_reg;
        case (cmd.op)
            OP_LOAD:   x_next = level;
            OP_FILT:   s_next = 24'($signed({28'd0, s_reg}) + p16);
            OP_NORM0:
            begin
                norm_next = s_reg;
                p_next    = 5'd23;
                zero_next = (s_reg == 24'd0);
            end
            OP_NORM:
            begin
                if ((norm_reg >> (24 - sh)) == 24'd0)
                begin
                    norm_next = norm_reg << sh;
                    p_next    = p_reg - sh;
                end
            end
            OP_INTERP: lg_next = lg_sum[22:0];
            OP_LOGMUL: over_next = ldb + 16'sd4608;
            OP_KNEE1:
            begin
                case (region)
                    RG_BELOW: t_next = 16'd0;
                    RG_KNEE:  tmp_next = prod_u[24:0];
                    RG_ABOVE: t_next = prod_u[30:15];
                    default:  t_next = 16'd0;
                endcase
            end
            OP_KNEE2:  tmp_next = 25'(prod_u >> knee_sh);
            OP_KNEE3:  t_next = 16'(prod_u >> 24);
            OP_BITE:   t_next = prod_u[31:16];
            OP_ATK:
            begin
                if (cfg.opto_enable)
                begin
                    if (big)
                        ca_next = FAST_ATK;
                    else if (atk_clamp)
                        ca_next = ATK_ROM[ATK_LAST];
                    else
                        ca_next = 16'($signed({36'd0, atk_lo}) + p16);
                end
                else
                begin
                    ca_next = cfg.attack_coeff;
                    cr_next = cfg.release_coeff;
                    r_next  = tq;
                end
            end
            OP_MEM:    r_next = 24'($signed({28'd0, r_reg}) + p16);
            OP_REL:
            begin
                if (rel_clamp)
                    cr_next = REL_ROM[REL_LAST];
                else
                    cr_next = 16'($signed({36'd0, rel_lo}) + p16);
            end
            OP_GAIN:   g_next = 24'($signed({28'd0, g_reg}) + p16);
            OP_OUT:    out_next = (g_reg[23:22] != 2'd0) ? 14'h3fff : g_reg[21:8];
            default:   x_next = x_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg <= '0;
            g_reg <= '0;
            r_reg <= '0;
        end
        else
        begin
            s_reg <= s_next;
            g_reg <= g_next;
            r_reg <= r_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        norm_reg <= norm_next;
        p_reg    <= p_next;
        zero_reg <= zero_next;
        lg_reg   <= lg_next;
        over_reg <= over_next;
        tmp_reg  <= tmp_next;
        t_reg    <= t_next;
        ca_reg   <= ca_next;
        cr_reg   <= cr_next;
        out_reg  <= out_next;
    end

    assign gain_reduction = out_reg;

endmodule

/* sv/cgd_ctrl.sv */
// Controller of the gain detector: sequences the datapath steps of one sample
// and runs both stream handshakes. Depends on cgd_pkg.
module cgd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  cgd_pkg::status_t sts,
    output cgd_pkg::cmd_t    cmd
);
    import cgd_pkg::*;

    typedef enum logic [14:0] {
        ST_IDLE   = 15'h0001,
        ST_FILT   = 15'h0002,
        ST_NORM0  = 15'h0004,
        ST_NORM   = 15'h0008,
        ST_INTERP = 15'h0010,
        ST_LOGMUL = 15'h0020,
        ST_KNEE1  = 15'h0040,
        ST_KNEE2  = 15'h0080,
        ST_KNEE3  = 15'h0100,
        ST_BITE   = 15'h0200,
        ST_ATK    = 15'h0400,
        ST_MEM    = 15'h0800,
        ST_REL    = 15'h1000,
        ST_GAIN   = 15'h2000,
        ST_DONE   = 15'h4000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       load_out;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd.op     = OP_NONE;
        cmd.step   = step_reg;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_FILT;
                end
            end
            ST_FILT:
            begin
                cmd.op     = OP_FILT;
                state_next = ST_NORM0;
            end
            ST_NORM0:
            begin
                cmd.op     = OP_NORM0;
                step_next  = 3'd0;
                state_next = ST_NORM;
            end
            ST_NORM:
            begin
                // Shifts of 16, 8, 4, 2 and 1 bring the leading one to the top.
                cmd.op = OP_NORM;
                if (step_reg == 3'd4)
                    state_next = ST_INTERP;
                else
                    step_next = step_reg + 3'd1;
            end
            ST_INTERP:
            begin
                cmd.op     = OP_INTERP;
                state_next = ST_LOGMUL;
            end
            ST_LOGMUL:
            begin
                cmd.op     = OP_LOGMUL;
                state_next = ST_KNEE1;
            end
            ST_KNEE1:
            begin
                cmd.op     = OP_KNEE1;
                state_next = (sts.region == RG_KNEE) ? ST_KNEE2 : ST_BITE;
            end
            ST_KNEE2:
            begin
                cmd.op     = OP_KNEE2;
                state_next = ST_KNEE3;
            end
            ST_KNEE3:
            begin
                cmd.op     = OP_KNEE3;
                state_next = ST_BITE;
            end
            ST_BITE:
            begin
                cmd.op     = OP_BITE;
                state_next = ST_ATK;
            end
            ST_ATK:
            begin
                cmd.op     = OP_ATK;
                state_next = sts.opto ? ST_MEM : ST_GAIN;
            end
            ST_MEM:
            begin
                cmd.op     = OP_MEM;
                state_next = ST_REL;
            end
            ST_REL:
            begin
                cmd.op     = OP_REL;
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                cmd.op     = OP_GAIN;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.op     = OP_OUT;
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid_next = (m_tvalid_reg && !m_tready) || load_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= 3'd0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again while a sample is in progress");

    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) && m_tvalid_reg && !m_tready
        |=> (state_reg == ST_DONE) && m_tvalid_reg)
        else $error("pending result overwritten");

    a_out_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> m_tvalid_reg)
        else $error("loaded result not presented");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NORM) |-> (step_reg <= 3'd4))
        else $error("normalize step out of range");
`endif

endmodule

/* sv/compressor_gain_detector_unit.sv */
// Compressor gain detector: level smoother, dB conversion, soft-knee gain computer
// and attack/release smoothing around one shared 26x26 multiplier.
// A new sample waits until the last result is loaded for output; each arithmetic step
// uses the multiplier once, the knee adds two steps and opto mode two more.
// rst_n clears the filter state, the handshakes and loads the register defaults;
// no clearing pass is needed.
module compressor_gain_detector_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] level
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [13:0] gain_reduction, [15:14] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cgd_pkg::*;

    cfg_t        cfg;
    cmd_t        cmd;
    status_t     sts;
    logic [13:0] gain_reduction;

    cgd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cgd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cgd_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .level          (s_tdata),
        .sts            (sts),
        .gain_reduction (gain_reduction)
    );

    assign m_tdata = {2'b00, gain_reduction};

endmodule
